// ===== rtl/core/cnv_pkg.sv =====
// Shared constants, register indexes and controller state type for the
// 3x3 normalized convolution filter. No dependencies.
package cnv_pkg;

    localparam int MAX_COLS_DEF   = 1024;
    localparam int COEF_WIDTH_DEF = 16;
    localparam int PIX_W          = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 48;
    localparam int COLS_W         = 11;
    localparam int ROWS_W         = 16;
    localparam int KSIDE          = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_TOP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_MID = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_BOT = 3'd4;

    localparam logic [COLS_W-1:0]     RST_IMAGE_COLS = 11'd1024;
    localparam logic [ROWS_W-1:0]     RST_IMAGE_ROWS = 16'd1024;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_EDGE  = 48'hFFFF_FFFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_MID   = 48'hFFFF_0001_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_START,
        ST_DIV
    } state_t;

endpackage

// ===== rtl/core/cnv_if.sv =====
// Valid/ready channel interfaces for pixel words in and result words out.
// Depends on cnv_pkg.
interface cnv_in_if;
    logic                     valid;
    logic                     ready;
    logic [cnv_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface cnv_out_if;
    logic                     valid;
    logic                     ready;
    logic [cnv_pkg::PIX_W-1:0] pixel_out;
    logic                     end_of_row;
    logic                     end_of_frame;

    modport source (output valid, output pixel_out, output end_of_row,
                    output end_of_frame, input ready);
    modport sink   (input valid, input pixel_out, input end_of_row,
                    input end_of_frame, output ready);
endinterface

// ===== rtl/core/cnv_col_cell.sv =====
// One window column cell: holds three pixels, hands them to its left
// neighbor on shift, and registers its weighted column sum. Uses cnv_pkg.
module cnv_col_cell #(
    parameter int COEF_W = cnv_pkg::COEF_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            shift,
    input  logic [cnv_pkg::PIX_W-1:0]       col_in   [cnv_pkg::KSIDE],
    input  logic signed [COEF_W-1:0]        coef     [cnv_pkg::KSIDE],
    output logic [cnv_pkg::PIX_W-1:0]       col_out  [cnv_pkg::KSIDE],
    output logic signed [COEF_W+10:0]       col_sum,
    output logic signed [COEF_W+1:0]        coef_sum
);
    import cnv_pkg::*;

    localparam int PROD_W = COEF_W + PIX_W + 1;

    logic [PIX_W-1:0]          pix_reg [KSIDE];
    logic signed [PROD_W-1:0]  prod [KSIDE];
    logic signed [PROD_W+1:0]  sum_reg;
    logic signed [PROD_W+1:0]  sum_next;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            pix_reg <= col_in;
        end
        sum_reg <= sum_next;
    end

    always_comb
    begin
        for (int i = 0; i < KSIDE; i++)
        begin
            prod[i] = $signed({1'b0, pix_reg[i]}) * coef[i];
        end
        sum_next = (PROD_W+2)'(prod[0]) + (PROD_W+2)'(prod[1]) + (PROD_W+2)'(prod[2]);
        coef_sum = (COEF_W+2)'(coef[0]) + (COEF_W+2)'(coef[1]) + (COEF_W+2)'(coef[2]);
    end

    assign col_out = pix_reg;
    assign col_sum = sum_reg;

endmodule

// ===== rtl/core/cnv_div.sv =====
// Bit-serial signed divider, one quotient bit per cycle, truncating toward
// zero; returns the low byte of the quotient. Uses cnv_pkg.
module cnv_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [NUM_W-1:0]      num,
    input  logic signed [DEN_W-1:0]      den,
    output logic                         done,
    output logic [cnv_pkg::PIX_W-1:0]    quot
);
    import cnv_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] dvs_reg, dvs_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   rem_sh;
    logic             fit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        rem_sh    = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        fit       = rem_sh >= {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            // take magnitudes, keep the result sign
            quo_next  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            dvs_next  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            neg_next  = num[NUM_W-1] ^ den[DEN_W-1];
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = fit ? rem_sh - {1'b0, dvs_reg} : rem_sh;
            quo_next = {quo_reg[NUM_W-2:0], fit};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? PIX_W'(-quo_reg[PIX_W-1:0]) : quo_reg[PIX_W-1:0];

endmodule

// ===== rtl/core/conv3x3_normalized_image_filter.sv =====
// Top level of the 3x3 normalized convolution filter; instantiates
// cnv_col_cell and cnv_div. Depends on cnv_pkg and cnv_if.
//
// Grey pixels enter in raster order, one word per handshake. Two line stores
// (MAX_COLS x 8 each) keep the two rows above, and a chain of three column
// cells forms the 3x3 window. Each interior pixel yields one result word:
// the signed window sum divided by the kernel's coefficient sum (1 when that
// sum is zero), truncated toward zero, low 8 bits kept; border pixels yield
// nothing. Rate: one pixel at a time. A border pixel passes through accept,
// window load, column sums and decision; an interior pixel also passes
// through the bit-serial divider, which resolves one quotient bit per cycle
// over the COEF_WIDTH+13 bit window sum. A finished result waits in the
// output register while the next pixel is taken. The line stores need no
// clearing pass. Configuration is written through cfg_we/cfg_addr/cfg_wdata;
// the user must write it only while idle; the block does not enforce this.
module conv3x3_normalized_image_filter #(
    parameter int MAX_COLS   = cnv_pkg::MAX_COLS_DEF,
    parameter int COEF_WIDTH = cnv_pkg::COEF_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    cnv_in_if.sink                              pixels,
    cnv_out_if.source                           results,
    input  logic                                cfg_we,
    input  logic [cnv_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [cnv_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import cnv_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int EXT_W = (CNT_W > COLS_W) ? CNT_W : COLS_W;
    localparam int ACC_W = COEF_WIDTH + 13;
    localparam int KS_W  = COEF_WIDTH + 4;
    localparam int CSUM_W = COEF_WIDTH + 11;
    localparam int CKS_W  = COEF_WIDTH + 2;

    // configuration registers
    logic [COLS_W-1:0]     cols_reg;
    logic [ROWS_W-1:0]     rows_reg;
    logic [CFG_DATA_W-1:0] coef_reg [KSIDE];

    // raster position
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROWS_W-1:0] row_reg, row_next;

    // item in flight
    logic [COL_W-1:0]  addr_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic              inner_reg, eor_reg, eof_reg;

    // line stores and their registered read data
    logic [PIX_W-1:0]  store_a [MAX_COLS];
    logic [PIX_W-1:0]  store_b [MAX_COLS];
    logic [PIX_W-1:0]  rd_a_reg, rd_b_reg;

    // output register
    logic              ovalid_reg, ovalid_next;
    logic [PIX_W-1:0]  opix_reg;
    logic              oeor_reg, oeof_reg;

    state_t            state_reg, state_next;

    logic [EXT_W-1:0]  cols_ext, cols_eff;
    logic [ROWS_W-1:0] rows_eff;
    logic              last_col, last_row, accept;
    logic              shift, div_start, div_done, load_out;
    logic [PIX_W-1:0]  div_quot;

    logic signed [COEF_WIDTH-1:0] coef [KSIDE][KSIDE];
    logic [PIX_W-1:0]             cell_col [KSIDE+1][KSIDE];
    logic signed [CSUM_W-1:0]     col_sum [KSIDE];
    logic signed [CKS_W-1:0]      col_ks [KSIDE];
    logic signed [ACC_W-1:0]      acc;
    logic signed [KS_W-1:0]       ksum, divisor;

    assign accept = pixels.valid && pixels.ready;
    assign pixels.ready = (state_reg == ST_IDLE);

    // config write port: unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg    <= RST_IMAGE_COLS;
            rows_reg    <= RST_IMAGE_ROWS;
            coef_reg[0] <= RST_COEF_EDGE;
            coef_reg[1] <= RST_COEF_MID;
            coef_reg[2] <= RST_COEF_EDGE;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_IMAGE_COLS:   cols_reg    <= cfg_wdata[COLS_W-1:0];
                REG_IMAGE_ROWS:   rows_reg    <= cfg_wdata[ROWS_W-1:0];
                REG_COEF_ROW_TOP: coef_reg[0] <= cfg_wdata;
                REG_COEF_ROW_MID: coef_reg[1] <= cfg_wdata;
                REG_COEF_ROW_BOT: coef_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamp frame geometry
    always_comb
    begin
        cols_ext = EXT_W'(cols_reg);
        if (cols_ext < EXT_W'(3))
            cols_eff = EXT_W'(3);
        else if (cols_ext > EXT_W'(MAX_COLS))
            cols_eff = EXT_W'(MAX_COLS);
        else
            cols_eff = cols_ext;
        rows_eff = (rows_reg < ROWS_W'(3)) ? ROWS_W'(3) : rows_reg;
        last_col = EXT_W'(col_reg) >= cols_eff - EXT_W'(1);
        last_row = row_reg >= rows_eff - ROWS_W'(1);
        col_next = last_col ? '0 : col_reg + COL_W'(1);
        row_next = last_col ? (last_row ? '0 : row_reg + ROWS_W'(1)) : row_reg;
    end

    // advance the raster position on every accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg  <= col_reg;
            pix_reg   <= pixels.pixel_in;
            inner_reg <= (row_reg >= ROWS_W'(2)) && (col_reg >= COL_W'(2));
            eor_reg   <= last_col;
            eof_reg   <= last_col && last_row;
        end
    end

    // line stores: read at accept, write back the shifted column on load
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_a_reg <= store_a[col_reg];
            rd_b_reg <= store_b[col_reg];
        end
        if (shift)
        begin
            store_a[addr_reg] <= pix_reg;
            store_b[addr_reg] <= rd_a_reg;
        end
    end

    // coefficient slots: left column in the low bits
    always_comb
    begin
        for (int r = 0; r < KSIDE; r++)
        begin
            for (int c = 0; c < KSIDE; c++)
            begin
                coef[r][c] = coef_reg[r][16*c +: COEF_WIDTH];
            end
        end
    end

    // new column enters the rightmost cell, older columns move left
    assign cell_col[KSIDE][0] = rd_b_reg;
    assign cell_col[KSIDE][1] = rd_a_reg;
    assign cell_col[KSIDE][2] = pix_reg;

    for (genvar j = 0; j < KSIDE; j++)
    begin : g_cell
        logic signed [COEF_WIDTH-1:0] cell_coef [KSIDE];

        always_comb
        begin
            for (int r = 0; r < KSIDE; r++)
            begin
                cell_coef[r] = coef[r][j];
            end
        end

        cnv_col_cell #(
            .COEF_W (COEF_WIDTH)
        ) u_cell (
            .clk      (clk),
            .shift    (shift),
            .col_in   (cell_col[j+1]),
            .coef     (cell_coef),
            .col_out  (cell_col[j]),
            .col_sum  (col_sum[j]),
            .coef_sum (col_ks[j])
        );
    end

    always_comb
    begin
        acc  = ACC_W'(col_sum[0]) + ACC_W'(col_sum[1]) + ACC_W'(col_sum[2]);
        ksum = KS_W'(col_ks[0]) + KS_W'(col_ks[1]) + KS_W'(col_ks[2]);
        divisor = (ksum == '0) ? KS_W'(1) : ksum;
    end

    cnv_div #(
        .NUM_W (ACC_W),
        .DEN_W (KS_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc),
        .den   (divisor),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            opix_reg <= div_quot;
            oeor_reg <= eor_reg;
            oeof_reg <= eof_reg;
        end
    end

    // sequencer: load window, let cells sum, then divide interior pixels
    always_comb
    begin
        state_next  = state_reg;
        shift       = 1'b0;
        div_start   = 1'b0;
        load_out    = 1'b0;
        ovalid_next = ovalid_reg && !results.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                shift      = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                if (inner_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                // hold the quotient until the output register frees up
                if (div_done && (!ovalid_reg || results.ready))
                begin
                    load_out    = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign results.valid        = ovalid_reg;
    assign results.pixel_out    = opix_reg;
    assign results.end_of_row   = oeor_reg;
    assign results.end_of_frame = oeof_reg;

endmodule

// ===== rtl/core/cnv_chk.sv =====
// Port-level checker for the 3x3 filter top level, attached by bind.
// Depends on the top level's channel interfaces.
module cnv_chk (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_eor,
    input logic out_eof
);
    logic in_acc;
    assign in_acc = in_valid && in_ready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_eof |-> out_eor)
        else $error("end of frame without end of row");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("second word taken while one is in work");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_acc, 1) && !$past(in_acc, 2) && !$past(in_acc, 3))
        else $error("result appeared too soon after a word");

endmodule

bind conv3x3_normalized_image_filter cnv_chk u_cnv_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixels.valid),
    .in_ready  (pixels.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_eor   (results.end_of_row),
    .out_eof   (results.end_of_frame)
);
